// ===== rtl/imu_sfp_pkg.sv =====
// Shared types and constants for the IMU serial frame parser.
`timescale 1ns / 1ps

package imu_sfp_pkg;

  // Frame layout: header, type, eight data bytes, checksum
  localparam int FRAME_BYTES = 11;
  localparam int POS_W       = 4;
  localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
  // Highest slot kept in the byte store (the checksum byte is never stored)
  localparam int STORE_LAST  = FRAME_BYTES - 2;

  // Byte codes
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_MAG   = 8'h54;

  // Result status codes
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_BAD_TYPE = 2'd2
  } status_t;

  // Frame kind codes
  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_MAG   = 2'd3
  } kind_t;

endpackage

// ===== rtl/imu_serial_frame_parser_unit.sv =====
// IMU serial frame parser: header hunt, byte collection, checksum and decode.
`timescale 1ns / 1ps

// Takes one received byte per transaction and can accept a byte in every cycle.
// Bytes are dropped until the header 0x55 is seen, after which ten more bytes
// are collected whatever their value. The last one is checked against a running
// 8-bit sum. Each completed frame gives one result on the output register in the
// cycle after its checksum byte is accepted: status, kind, four little-endian
// signed words, the sticky mask of kinds seen and the good-frame and
// checksum-error counters (both wrap at 32 bits). A checksum error takes
// precedence over an unknown type byte. Kind and words read zero unless status
// is good. The input stalls only on a checksum byte that arrives while the
// previous result is still held on a stalled output. All other bytes are
// accepted as usual.
module imu_serial_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // frame result
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_kind,
  output logic signed [15:0] out_value_a,
  output logic signed [15:0] out_value_b,
  output logic signed [15:0] out_value_c,
  output logic signed [15:0] out_value_d,
  output logic [3:0]  out_valid_kinds,
  output logic [31:0] out_good_frames,
  output logic [31:0] out_bad_checksums
);

  // Frame tracking state
  logic [imu_sfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  store_r [1:imu_sfp_pkg::STORE_LAST];
  logic [3:0]  mask_r, mask_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  imu_sfp_pkg::status_t status_r, status_nxt;
  imu_sfp_pkg::kind_t   kind_r, kind_nxt;
  logic [15:0] va_r, va_nxt;
  logic [15:0] vb_r, vb_nxt;
  logic [15:0] vc_r, vc_nxt;
  logic [15:0] vd_r, vd_nxt;

  logic in_fire;
  logic last_byte;
  logic type_ok;
  imu_sfp_pkg::kind_t type_kind;

  // Handshake: hold back a checksum byte only while a result is blocked
  assign last_byte = (pos_r == imu_sfp_pkg::POS_LAST);
  assign in_stall  = out_valid_r && out_stall && last_byte;
  assign in_fire   = in_valid && !in_stall;

  // Type byte decode
  always_comb begin
    type_ok   = 1'b0;
    type_kind = imu_sfp_pkg::KIND_ACCEL;
    case (store_r[1]) inside
      [imu_sfp_pkg::TYPE_ACCEL:imu_sfp_pkg::TYPE_MAG]: begin
        type_ok   = 1'b1;
        type_kind = imu_sfp_pkg::kind_t'(2'(store_r[1] - imu_sfp_pkg::TYPE_ACCEL));
      end
      default: begin
        type_ok = 1'b0;
      end
    endcase
  end

  // Next state and result
  always_comb begin
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    mask_nxt      = mask_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    kind_nxt      = kind_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    vc_nxt        = vc_r;
    vd_nxt        = vd_r;
    if (in_fire) begin
      if (pos_r == imu_sfp_pkg::POS_HUNT) begin
        // hunting for the header
        if (in_byte == imu_sfp_pkg::HDR_BYTE) begin
          pos_nxt = imu_sfp_pkg::POS_W'(1);
          sum_nxt = imu_sfp_pkg::HDR_BYTE;
        end
      end else if (!last_byte) begin
        pos_nxt = pos_r + imu_sfp_pkg::POS_W'(1);
        sum_nxt = sum_r + in_byte;
      end else begin
        // checksum byte closes the frame
        pos_nxt       = imu_sfp_pkg::POS_HUNT;
        out_valid_nxt = 1'b1;
        kind_nxt      = imu_sfp_pkg::KIND_ACCEL;
        va_nxt        = 16'd0;
        vb_nxt        = 16'd0;
        vc_nxt        = 16'd0;
        vd_nxt        = 16'd0;
        if (sum_r != in_byte) begin
          status_nxt = imu_sfp_pkg::ST_CSUM_ERR;
          bad_nxt    = bad_r + 32'd1;
        end else if (!type_ok) begin
          status_nxt = imu_sfp_pkg::ST_BAD_TYPE;
        end else begin
          status_nxt = imu_sfp_pkg::ST_GOOD;
          kind_nxt   = type_kind;
          mask_nxt   = mask_r | (4'b0001 << type_kind);
          good_nxt   = good_r + 32'd1;
          va_nxt     = {store_r[3], store_r[2]};
          vb_nxt     = {store_r[5], store_r[4]};
          vc_nxt     = {store_r[7], store_r[6]};
          vd_nxt     = {store_r[9], store_r[8]};
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= imu_sfp_pkg::POS_HUNT;
      mask_r      <= 4'd0;
      good_r      <= 32'd0;
      bad_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      mask_r      <= mask_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    status_r <= status_nxt;
    kind_r   <= kind_nxt;
    va_r     <= va_nxt;
    vb_r     <= vb_nxt;
    vc_r     <= vc_nxt;
    vd_r     <= vd_nxt;
  end

  // Frame byte store: type and data bytes land in their slot
  always_ff @(posedge clk) begin
    if (in_fire && (pos_r != imu_sfp_pkg::POS_HUNT) && !last_byte) begin
      store_r[pos_r] <= in_byte;
    end
  end

  // Outputs; counters and mask cannot move while a result is held
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_kind          = kind_r;
  assign out_value_a       = va_r;
  assign out_value_b       = vb_r;
  assign out_value_c       = vc_r;
  assign out_value_d       = vd_r;
  assign out_valid_kinds   = mask_r;
  assign out_good_frames   = good_r;
  assign out_bad_checksums = bad_r;

  // Checks
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result held");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= imu_sfp_pkg::POS_LAST)
    else $error("byte position out of range");

  a_frame_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_byte) |=> (out_valid_r && pos_r == imu_sfp_pkg::POS_HUNT))
    else $error("closed frame did not produce a result");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != imu_sfp_pkg::ST_GOOD) |->
      (kind_r == imu_sfp_pkg::KIND_ACCEL && va_r == 16'd0 && vd_r == 16'd0))
    else $error("failed frame carries kind or data");

  a_good_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_byte) |=>
      ((status_r == imu_sfp_pkg::ST_GOOD) == (good_r != $past(good_r))))
    else $error("good frame counter out of step with status");

endmodule

// ===== tb/tb_imu_serial_frame_parser_unit.sv =====
// Self-checking testbench for the IMU serial frame parser: byte stream in, frame results out.
`timescale 1ns / 1ps

module tb_imu_serial_frame_parser_unit;

  // One decoded frame result
  typedef struct {
    imu_sfp_pkg::status_t status;
    imu_sfp_pkg::kind_t   kind;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [15:0] value_c;
    logic signed [15:0] value_d;
    logic [3:0]        valid_kinds;
    logic [31:0]       good_frames;
    logic [31:0]       bad_checksums;
  } frame_result_t;

  // Frame decoder model plus the queue of frame results still owed by the block
  class frame_scoreboard;
    logic [imu_sfp_pkg::POS_W-1:0] byte_pos;
    logic [7:0]       frame_bytes [0:imu_sfp_pkg::STORE_LAST];
    logic [3:0]       kinds_seen;
    logic [31:0]      good_count;
    logic [31:0]      csum_err_count;
    frame_result_t    owed_frames [$];
    int               errors;
    int               n_good;
    int               n_csum;
    int               n_bad_type;

    function new();
      byte_pos       = imu_sfp_pkg::POS_HUNT;
      kinds_seen     = '0;
      good_count     = '0;
      csum_err_count = '0;
      errors         = 0;
      n_good         = 0;
      n_csum         = 0;
      n_bad_type     = 0;
      for (int i = 0; i <= imu_sfp_pkg::STORE_LAST; i++) frame_bytes[i] = '0;
    endfunction

    // Advance the decoder by one accepted byte; returns 0 if the byte was dropped
    function bit note_byte(logic [7:0] b);
      frame_result_t r;
      logic [7:0]    sum;
      bit            known;
      if (byte_pos == imu_sfp_pkg::POS_HUNT) begin
        if (b == imu_sfp_pkg::HDR_BYTE) begin
          frame_bytes[0] = b;
          byte_pos = imu_sfp_pkg::POS_W'(1);
          return 1'b1;
        end
        return 1'b0;
      end
      if (byte_pos < imu_sfp_pkg::POS_LAST) begin
        frame_bytes[byte_pos] = b;
        byte_pos = byte_pos + imu_sfp_pkg::POS_W'(1);
        return 1'b1;
      end
      // checksum byte closes the frame
      byte_pos = imu_sfp_pkg::POS_HUNT;
      sum = '0;
      for (int i = 0; i <= imu_sfp_pkg::STORE_LAST; i++) sum = sum + frame_bytes[i];
      r.status  = imu_sfp_pkg::ST_GOOD;
      r.kind    = imu_sfp_pkg::KIND_ACCEL;
      r.value_a = '0;
      r.value_b = '0;
      r.value_c = '0;
      r.value_d = '0;
      known     = 1'b1;
      if (sum != b) begin
        csum_err_count = csum_err_count + 32'd1;
        r.status = imu_sfp_pkg::ST_CSUM_ERR;
      end else begin
        case (frame_bytes[1])
          imu_sfp_pkg::TYPE_ACCEL: r.kind = imu_sfp_pkg::KIND_ACCEL;
          imu_sfp_pkg::TYPE_GYRO:  r.kind = imu_sfp_pkg::KIND_GYRO;
          imu_sfp_pkg::TYPE_ANGLE: r.kind = imu_sfp_pkg::KIND_ANGLE;
          imu_sfp_pkg::TYPE_MAG:   r.kind = imu_sfp_pkg::KIND_MAG;
          default:                 known  = 1'b0;
        endcase
        if (known) begin
          kinds_seen = kinds_seen | (4'b0001 << r.kind);
          good_count = good_count + 32'd1;
          r.value_a  = {frame_bytes[3], frame_bytes[2]};
          r.value_b  = {frame_bytes[5], frame_bytes[4]};
          r.value_c  = {frame_bytes[7], frame_bytes[6]};
          r.value_d  = {frame_bytes[9], frame_bytes[8]};
        end else begin
          r.status = imu_sfp_pkg::ST_BAD_TYPE;
        end
      end
      r.valid_kinds   = kinds_seen;
      r.good_frames   = good_count;
      r.bad_checksums = csum_err_count;
      owed_frames.push_back(r);
      return 1'b1;
    endfunction

    function int pending();
      return owed_frames.size();
    endfunction

    function void field_cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    // Compare one result transaction with the oldest owed frame
    function void check_result(frame_result_t act);
      frame_result_t e;
      if (owed_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual status %h",
                 $time, act.status);
        return;
      end
      e = owed_frames.pop_front();
      case (e.status)
        imu_sfp_pkg::ST_GOOD:     n_good++;
        imu_sfp_pkg::ST_CSUM_ERR: n_csum++;
        default:                  n_bad_type++;
      endcase
      field_cmp("status", 32'(e.status), 32'(act.status));
      field_cmp("kind", 32'(e.kind), 32'(act.kind));
      field_cmp("value_a", 32'(e.value_a), 32'(act.value_a));
      field_cmp("value_b", 32'(e.value_b), 32'(act.value_b));
      field_cmp("value_c", 32'(e.value_c), 32'(act.value_c));
      field_cmp("value_d", 32'(e.value_d), 32'(act.value_d));
      field_cmp("valid_kinds", 32'(e.valid_kinds), 32'(act.valid_kinds));
      field_cmp("good_frames", e.good_frames, act.good_frames);
      field_cmp("bad_checksums", e.bad_checksums, act.bad_checksums);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [1:0]  out_kind;
  logic signed [15:0] out_value_a;
  logic signed [15:0] out_value_b;
  logic signed [15:0] out_value_c;
  logic signed [15:0] out_value_d;
  logic [3:0]  out_valid_kinds;
  logic [31:0] out_good_frames;
  logic [31:0] out_bad_checksums;

  frame_scoreboard sb;
  int src_idle_pct;
  int sink_stall_pct;
  int bytes_used;
  int bytes_sent;

  imu_serial_frame_parser_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_kind          (out_kind),
    .out_value_a       (out_value_a),
    .out_value_b       (out_value_b),
    .out_value_c       (out_value_c),
    .out_value_d       (out_value_d),
    .out_valid_kinds   (out_valid_kinds),
    .out_good_frames   (out_good_frames),
    .out_bad_checksums (out_bad_checksums)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result receiver: random stall, changed on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    frame_result_t act;
    if (rst_n && out_valid && !out_stall) begin
      act.status        = imu_sfp_pkg::status_t'(out_status);
      act.kind          = imu_sfp_pkg::kind_t'(out_kind);
      act.value_a       = out_value_a;
      act.value_b       = out_value_b;
      act.value_c       = out_value_c;
      act.value_d       = out_value_d;
      act.valid_kinds   = out_valid_kinds;
      act.good_frames   = out_good_frames;
      act.bad_checksums = out_bad_checksums;
      sb.check_result(act);
    end
  end

  // Drive one byte and wait for its transaction; valid stays high afterwards
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    bytes_sent++;
    if (sb.note_byte(b)) bytes_used++;
  endtask

  // Send the first n_bytes of a frame; the checksum is right unless csum_off is nonzero
  task automatic send_frame(input logic [7:0] ftype, input logic [63:0] words,
                            input logic [7:0] csum_off, input int n_bytes);
    logic [7:0] fb [0:imu_sfp_pkg::FRAME_BYTES-1];
    logic [7:0] sum;
    fb[0] = imu_sfp_pkg::HDR_BYTE;
    fb[1] = ftype;
    sum   = imu_sfp_pkg::HDR_BYTE + ftype;
    for (int i = 0; i < 8; i++) begin
      fb[2 + i] = words[8*i +: 8];
      sum = sum + words[8*i +: 8];
    end
    fb[imu_sfp_pkg::FRAME_BYTES-1] = sum + csum_off;
    for (int i = 0; i < n_bytes; i++) send_byte(fb[i]);
  endtask

  function automatic logic [15:0] rand_word();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0:       w = 16'h8000;
        1:       w = 16'h7FFF;
        2:       w = 16'h0000;
        default: w = 16'hFFFF;
      endcase
    end
    return w;
  endfunction

  // Random frame traffic: mostly well-formed, with noise, bad sums, odd types, cut frames
  task automatic random_traffic(input int n_bytes);
    logic [7:0]  ftype;
    logic [63:0] words;
    logic [7:0]  csum_off;
    int          n_send;
    int          roll;
    while (bytes_used < n_bytes) begin
      // phase of idling follows progress through the random part
      if (bytes_used < n_bytes / 3) begin
        src_idle_pct = 9;  sink_stall_pct = 49;
      end else if (bytes_used < (2 * n_bytes) / 3) begin
        src_idle_pct = 49; sink_stall_pct = 9;
      end else begin
        src_idle_pct = 0;  sink_stall_pct = 0;
      end
      // line noise between frames
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      end
      roll = $urandom_range(99);
      if (roll < 80) ftype = imu_sfp_pkg::TYPE_ACCEL + 8'($urandom_range(3));
      else           ftype = 8'($urandom);
      words    = {rand_word(), rand_word(), rand_word(), rand_word()};
      csum_off = ($urandom_range(99) < 15) ? 8'($urandom_range(255, 1)) : 8'd0;
      n_send   = ($urandom_range(99) < 8) ? $urandom_range(imu_sfp_pkg::FRAME_BYTES - 1, 1)
                                          : imu_sfp_pkg::FRAME_BYTES;
      send_frame(ftype, words, csum_off, n_send);
    end
  endtask

  // Main sequence
  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    bytes_used     = 0;
    bytes_sent     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: noise while hunting, extreme words with a header byte inside the
    // frame, then a bad checksum on an unknown type (checksum must win)
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(imu_sfp_pkg::TYPE_ACCEL, {16'hFFFF, 16'h0055, 16'h7FFF, 16'h8000}, 8'd0,
               imu_sfp_pkg::FRAME_BYTES);
    send_frame(8'h00, {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'd1,
               imu_sfp_pkg::FRAME_BYTES);

    random_traffic(bytes_used + 450);

    @(negedge clk);
    in_valid <= 1'b0;

    // drain outstanding frames, then let the output register settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes (%0d used by frames); results: %0d good, %0d checksum error,",
             bytes_sent, bytes_used, sb.n_good, sb.n_csum);
    $display("%0d unknown type; kinds seen mask %b, idling phases sender 9/receiver 49, 49/9, none",
             sb.n_bad_type, sb.kinds_seen);
    if (sb.errors == 0) begin
      $display("imu_serial_frame_parser_unit: match");
    end else begin
      $display("imu_serial_frame_parser_unit: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500000;
    $display("imu_serial_frame_parser_unit: mismatch");
    $finish;
  end

endmodule
